// ===== rtl/mmrr_pkg.sv =====
// Package for the meter register responder: sizes, codes, the state encoding
// and the identity ROM. No dependencies.
package mmrr_pkg;

	localparam int MaxRegisters = 63;
	localparam int StoreWords   = 91;
	localparam int RomWords     = 80;
	localparam int RomLimit     = 71;
	localparam int SaW          = $clog2(StoreWords);

	localparam logic [15:0] WinLo     = 16'd40000;
	localparam logic [15:0] WinHi     = 16'd40197;
	localparam logic [7:0]  FnRead    = 8'h03;
	localparam logic [7:0]  FnExcept  = 8'h83;
	localparam logic [7:0]  ExcAddr   = 8'h02;
	localparam logic [7:0]  OffPower  = 8'd71;
	localparam logic [7:0]  OffEnergy = 8'd129;
	localparam logic [7:0]  OffAlias  = 8'd193;
	localparam logic [7:0]  OffMark   = 8'd195;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PRESET,
		ST_CALC,
		ST_WRITE,
		ST_HEADER,
		ST_READ,
		ST_DATA
	} state_t;

	// Identity ROM contents.
	function automatic logic [15:0] rom_word(input logic [6:0] a);
		logic [15:0] w;
		w = 16'h0000;
		unique case (a)
			7'd0:  w = 16'h7553; 7'd1:  w = 16'h536e; 7'd2:  w = 16'h0100;
			7'd3:  w = 16'h4100; 7'd4:  w = 16'h4100; 7'd5:  w = 16'h6d00;
			7'd6:  w = 16'h6900; 7'd7:  w = 16'h7300; 7'd8:  w = 16'h2000;
			7'd9:  w = 16'h5200; 7'd10: w = 16'h6500; 7'd11: w = 16'h6100;
			7'd12: w = 16'h6400; 7'd13: w = 16'h6500; 7'd14: w = 16'h7200;
			7'd20: w = 16'h5300; 7'd21: w = 16'h6d00; 7'd22: w = 16'h6100;
			7'd23: w = 16'h7200; 7'd24: w = 16'h7400; 7'd25: w = 16'h2000;
			7'd26: w = 16'h4d00; 7'd27: w = 16'h6500; 7'd28: w = 16'h7400;
			7'd29: w = 16'h6500; 7'd30: w = 16'h7200; 7'd31: w = 16'h2000;
			7'd32: w = 16'h3600; 7'd33: w = 16'h3300; 7'd34: w = 16'h4100;
			7'd52: w = 16'h3500; 7'd53: w = 16'h3400; 7'd54: w = 16'h3400;
			7'd55: w = 16'h3300; 7'd56: w = 16'h3300; 7'd57: w = 16'h3200;
			7'd58: w = 16'h3200; 7'd59: w = 16'h3100; 7'd68: w = 16'hf000;
			7'd69: w = 16'hd500; 7'd70: w = 16'h7c00;
			default: w = 16'h0000;
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/mmrr_float.sv =====
// Multi-cycle integer to IEEE-754 single converter, one shift step a cycle.
// Standalone module with no package dependencies.
module mmrr_float (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        neg,
	input  logic [31:0] mag,
	output logic        done,
	output logic [31:0] bits
);

	logic [31:0] m_q;
	logic [7:0]  e_q;
	logic        neg_q;
	logic        busy_q;
	logic        zero_q;
	logic [23:0] man;
	logic        rnd;
	logic [24:0] sum;

	// Rounding of the normalized mantissa (bit 31 leading).
	assign man = m_q[31:8];
	assign rnd = m_q[7] & ((|m_q[6:0]) | m_q[8]);
	assign sum = {1'b0, man} + {24'd0, rnd};

	// Normalize by shifting left one bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= (mag != 32'd0);
				done   <= (mag == 32'd0);
			end else if (busy_q && m_q[31]) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q    <= mag;
			e_q    <= 8'd158;
			neg_q  <= neg;
			zero_q <= (mag == 32'd0);
		end else if (busy_q && !m_q[31]) begin
			m_q <= {m_q[30:0], 1'b0};
			e_q <= e_q - 8'd1;
		end
	end

	always_comb begin
		if (zero_q) begin
			bits = 32'd0;
		end else if (sum[24]) begin
			bits = {neg_q, e_q + 8'd1, 23'd0};
		end else begin
			bits = {neg_q, e_q, sum[22:0]};
		end
	end

endmodule

// ===== rtl/modbus_meter_register_responder_unit.sv =====
// Top level of the meter register responder: sequencer, word store and
// output register. Uses mmrr_pkg and mmrr_float.
//
// channel | signals                              | dir
// in      | in_valid/in_ready + request fields  | in
// out     | out_valid/out_ready + reply fields  | out
//
// A bad request goes from idle straight to the header state, a plain read through
// the calc and header states and then a store read state and an output state per
// reply word. The first valid request after reset or after the store was released
// runs a clearing pass over all 91 store words and 5 preset writes. Each float
// conversion runs on one shared normalizer and is followed by writes of its two
// halves. Output stalls simply hold the sequencer; in_ready is high only in idle.
module modbus_meter_register_responder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] transaction_id,
	input  logic [15:0] protocol_id,
	input  logic [7:0]  unit_id,
	input  logic [7:0]  function_code,
	input  logic [15:0] start_register,
	input  logic [15:0] register_count,
	input  logic [31:0] energy_import,
	input  logic [31:0] energy_export,
	input  logic [30:0] power_import,
	input  logic [30:0] power_export,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_header,
	output logic [15:0] reply_transaction,
	output logic [15:0] reply_protocol,
	output logic [15:0] reply_length,
	output logic [7:0]  reply_unit,
	output logic [7:0]  reply_function,
	output logic [7:0]  byte_count_or_code,
	output logic [15:0] data_word,
	output logic        last
);

	mmrr_pkg::state_t state_q, state_d;

	logic [15:0] mem [mmrr_pkg::StoreWords];
	logic [15:0] rd_q;

	logic [15:0] tr_q, pr_q;
	logic [7:0]  un_q;
	logic [7:0]  off_q;
	logic [5:0]  cnt_q;
	logic [5:0]  k_q;
	logic        err_q;
	logic        rom_q;
	logic [7:0]  base_q;
	logic [31:0] eimp_q, eexp_q;
	logic [31:0] net_q, third_q;
	logic [2:0]  job_q;
	logic [6:0]  idx_q;
	logic        ready_q;
	logic        fstart_q;
	logic        cvt_q;
	logic [31:0] fb_q;
	logic        half_q;

	logic        f_done;
	logic [31:0] f_bits;
	logic        f_neg;
	logic [31:0] f_mag;
	logic [31:0] f_src;
	logic [6:0]  f_word;
	logic [2:0]  job_cnt;
	logic [31:0] third_calc;

	logic        bad;
	logic [15:0] off16;
	logic [8:0]  raddr;
	logic        rd_ok;
	logic        wr_en;
	logic [6:0]  wr_a;
	logic [15:0] wr_d;
	logic [31:0] diff;

	assign off16 = start_register - mmrr_pkg::WinLo;
	assign bad = (function_code != mmrr_pkg::FnRead) || (start_register < mmrr_pkg::WinLo)
		|| (start_register > mmrr_pkg::WinHi)
		|| (register_count > 16'(mmrr_pkg::MaxRegisters));
	assign in_ready = (state_q == mmrr_pkg::ST_IDLE);
	assign diff = {1'b0, power_import} - {1'b0, power_export};

	// Conversion jobs: power jobs 0..3, energy jobs 0..1.
	assign job_cnt = (off_q == mmrr_pkg::OffPower) ? 3'd4 : 3'd2;
	always_comb begin
		f_src  = 32'd0;
		f_word = 7'd0;
		if (off_q == mmrr_pkg::OffPower) begin
			unique case (job_q[1:0])
				2'd0: begin f_src = net_q;   f_word = 7'd26; end
				2'd1: begin f_src = third_q; f_word = 7'd28; end
				2'd2: begin f_src = third_q; f_word = 7'd30; end
				default: begin f_src = net_q - third_q - third_q; f_word = 7'd32; end
			endcase
			f_neg = f_src[31];
			f_mag = f_src[31] ? (32'd0 - f_src) : f_src;
		end else begin
			f_src  = job_q[0] ? eimp_q : eexp_q;
			f_word = job_q[0] ? 7'd66 : 7'd58;
			f_neg  = 1'b0;
			f_mag  = f_src;
		end
	end

	// Truncating division of the net power by three via reciprocal.
	always_comb begin
		logic [31:0] a;
		logic [31:0] q;
		a = net_q[31] ? (32'd0 - net_q) : net_q;
		q = 32'(({32'd0, a} * 64'hAAAAAAAB) >> 33);
		third_calc = net_q[31] ? (32'd0 - q) : q;
	end

	mmrr_float u_float (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fstart_q),
		.neg    (f_neg),
		.mag    (f_mag),
		.done   (f_done),
		.bits   (f_bits)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmrr_pkg::ST_IDLE:
				if (in_valid && (energy_import != 32'd0 || energy_export != 32'd0)) begin
					if (bad) state_d = mmrr_pkg::ST_HEADER;
					else if (!ready_q) state_d = mmrr_pkg::ST_CLEAR;
					else state_d = mmrr_pkg::ST_CALC;
				end
			mmrr_pkg::ST_CLEAR:
				if (idx_q == 7'(mmrr_pkg::StoreWords - 1)) state_d = mmrr_pkg::ST_PRESET;
			mmrr_pkg::ST_PRESET:
				if (idx_q == 7'd4) state_d = mmrr_pkg::ST_CALC;
			mmrr_pkg::ST_CALC:
				if (off_q != mmrr_pkg::OffPower && off_q != mmrr_pkg::OffEnergy)
					state_d = mmrr_pkg::ST_HEADER;
				else if (f_done) state_d = mmrr_pkg::ST_WRITE;
			mmrr_pkg::ST_WRITE:
				if (half_q) state_d = (job_q == job_cnt - 3'd1) ? mmrr_pkg::ST_HEADER
					: mmrr_pkg::ST_CALC;
			mmrr_pkg::ST_HEADER:
				if (!out_valid || out_ready) state_d = (err_q || cnt_q == 6'd0)
					? mmrr_pkg::ST_IDLE : mmrr_pkg::ST_READ;
			mmrr_pkg::ST_READ:
				state_d = mmrr_pkg::ST_DATA;
			mmrr_pkg::ST_DATA:
				if (!out_valid || out_ready) state_d = (k_q == cnt_q - 6'd1)
					? mmrr_pkg::ST_IDLE : mmrr_pkg::ST_READ;
			default: state_d = mmrr_pkg::ST_IDLE;
		endcase
	end

	// Store write port.
	always_comb begin
		wr_en = 1'b0;
		wr_a  = idx_q;
		wr_d  = 16'd0;
		unique case (state_q)
			mmrr_pkg::ST_CLEAR: wr_en = 1'b1;
			mmrr_pkg::ST_PRESET: begin
				wr_en = 1'b1;
				if (idx_q == 7'd4) begin
					wr_a = 7'd24;
					wr_d = 16'h4248;
				end else begin
					wr_a = 7'(8 + 2 * idx_q);
					wr_d = 16'h4366;
				end
			end
			mmrr_pkg::ST_WRITE: begin
				wr_en = 1'b1;
				wr_a  = f_word + {6'd0, half_q};
				wr_d  = half_q ? fb_q[15:0] : fb_q[31:16];
			end
			mmrr_pkg::ST_CALC: begin
				wr_en = (off_q == mmrr_pkg::OffMark);
				wr_a  = 7'd0;
				wr_d  = 16'hFFFF;
			end
			default: wr_en = 1'b0;
		endcase
	end

	assign raddr = {1'b0, base_q} + {3'd0, k_q};
	assign rd_ok = raddr < 9'(mmrr_pkg::StoreWords);

	// Word store.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_a] <= wr_d;
		if (rd_ok) rd_q <= mem[raddr[6:0]];
		else rd_q <= 16'd0;
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mmrr_pkg::ST_IDLE;
			ready_q  <= 1'b0;
			fstart_q <= 1'b0;
			cvt_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q  <= state_d;
			fstart_q <= 1'b0;
			unique case (state_q)
				mmrr_pkg::ST_IDLE:
					if (state_d != mmrr_pkg::ST_IDLE) begin
						cvt_q <= 1'b0;
						if (bad || off16 < 16'(mmrr_pkg::RomLimit)
							|| off16 == 16'(mmrr_pkg::OffMark))
							ready_q <= 1'b0;
						else ready_q <= 1'b1;
					end
				mmrr_pkg::ST_CALC:
					if (!cvt_q && (off_q == mmrr_pkg::OffPower
						|| off_q == mmrr_pkg::OffEnergy)) begin
						fstart_q <= 1'b1;
						cvt_q    <= 1'b1;
					end else if (f_done) cvt_q <= 1'b0;
				default: cvt_q <= cvt_q;
			endcase
			// The output word is valid from its load until it is taken.
			if ((state_q == mmrr_pkg::ST_HEADER || state_q == mmrr_pkg::ST_DATA)
				&& (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			mmrr_pkg::ST_IDLE: begin
				tr_q   <= transaction_id;
				pr_q   <= protocol_id;
				un_q   <= unit_id;
				off_q  <= off16[7:0];
				cnt_q  <= register_count[5:0];
				err_q  <= bad;
				rom_q  <= off16 < 16'(mmrr_pkg::RomLimit);
				base_q <= (off16 < 16'(mmrr_pkg::RomLimit)) ? off16[7:0]
					: (off16 == 16'(mmrr_pkg::OffMark) || off16 == 16'(mmrr_pkg::OffAlias))
					? 8'd0 : off16[7:0] - mmrr_pkg::OffPower;
				eimp_q <= energy_import;
				eexp_q <= energy_export;
				net_q  <= diff;
				idx_q  <= 7'd0;
				job_q  <= 3'd0;
				k_q    <= 6'd0;
				half_q <= 1'b0;
			end
			mmrr_pkg::ST_CLEAR: begin
				third_q <= third_calc;
				idx_q   <= (idx_q == 7'(mmrr_pkg::StoreWords - 1)) ? 7'd0 : idx_q + 7'd1;
			end
			mmrr_pkg::ST_PRESET: idx_q <= idx_q + 7'd1;
			mmrr_pkg::ST_CALC: begin
				third_q <= third_calc;
				if (f_done) fb_q <= f_bits;
			end
			mmrr_pkg::ST_WRITE: begin
				half_q <= !half_q;
				if (half_q) job_q <= job_q + 3'd1;
			end
			mmrr_pkg::ST_HEADER:
				if (!out_valid || out_ready) begin
					is_header          <= 1'b1;
					reply_transaction  <= tr_q;
					reply_protocol     <= pr_q;
					reply_length       <= err_q ? 16'd3 : 16'({cnt_q, 1'b0}) + 16'd3;
					reply_unit         <= un_q;
					reply_function     <= err_q ? mmrr_pkg::FnExcept : mmrr_pkg::FnRead;
					byte_count_or_code <= err_q ? mmrr_pkg::ExcAddr : {1'b0, cnt_q, 1'b0};
					data_word          <= 16'd0;
					last               <= err_q || cnt_q == 6'd0;
				end
			mmrr_pkg::ST_DATA:
				if (!out_valid || out_ready) begin
					is_header          <= 1'b0;
					reply_transaction  <= 16'd0;
					reply_protocol     <= 16'd0;
					reply_length       <= 16'd0;
					reply_unit         <= 8'd0;
					reply_function     <= 8'd0;
					byte_count_or_code <= 8'd0;
					data_word          <= rom_q ? ((raddr < 9'(mmrr_pkg::RomWords))
						? mmrr_pkg::rom_word(raddr[6:0]) : 16'd0) : rd_q;
					last               <= (k_q == cnt_q - 6'd1);
					k_q                <= k_q + 6'd1;
				end
			default: idx_q <= idx_q;
		endcase
	end

endmodule
